/* sv/ubds_pkg.sv */
// Package for the UART baud divisor search core.
// Holds register indexes, field widths and reset values; no dependencies.
package ubds_pkg;

  localparam int ClkW    = 28;
  localparam int TolW    = 14;
  localparam int BaudW   = 24;
  localparam int WordW   = 16;
  localparam int CfgIdxW = 1;
  localparam int NumW    = 48;
  localparam int MulAW   = 28;
  localparam int MulBW   = 24;
  localparam int ProdW   = MulAW + MulBW;
  localparam int CntW    = 6;

  localparam logic [ClkW-1:0] ClockHzReset   = ClkW'(8000000);
  localparam logic [TolW-1:0] ToleranceReset = TolW'(250);
  localparam logic [MulBW-1:0] BpScale       = MulBW'(10000);
  localparam logic [MulBW-1:0] RoundScale    = MulBW'(10);

  typedef enum logic [CfgIdxW-1:0] {
    REG_CLOCK_HZ  = 1'b0,
    REG_TOLERANCE = 1'b1
  } reg_index_t;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

endpackage

/* sv/ubds_in_if.sv */
// Input channel of the baud divisor search: valid/ready plus requested rate.
// Depends on ubds_pkg for the field width.
interface ubds_in_if;
  logic                         valid;
  logic                         ready;
  logic [ubds_pkg::BaudW-1:0]   bit_rate;

  modport source (output valid, output bit_rate, input ready);
  modport sink   (input valid, input bit_rate, output ready);
endinterface

/* sv/ubds_out_if.sv */
// Output channel of the baud divisor search: valid/ready plus the setting.
// Depends on ubds_pkg for the field widths.
interface ubds_out_if;
  logic                         valid;
  logic                         ready;
  logic                         status;
  logic [1:0]                   prescaler_sel;
  logic [ubds_pkg::WordW-1:0]   divisor_word;
  logic                         fraction_enable;

  modport source (output valid, output status, output prescaler_sel,
                  output divisor_word, output fraction_enable, input ready);
  modport sink   (input valid, input status, input prescaler_sel,
                  input divisor_word, input fraction_enable, output ready);
endinterface

/* sv/uart_baud_divisor_search_core.sv */
// UART baud divisor search core: top level.
// Depends on ubds_pkg, ubds_in_if and ubds_out_if.
//
// One word in, one word out. For a requested baud rate the core tries the
// prescalers 1, 4, 16 and 64 in order against clock_hz with 8x oversampling
// and returns the first one whose rate error is within tolerance_bp
// (1/10000 units), with the divisor word and fraction enable; status is 1
// for a zero rate or when nothing fits. All divisions run on one shared
// 48-step restoring divider and all products on one shared multiplier. The
// input is not ready while a word is in work or its result waits.
module uart_baud_divisor_search_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ubds_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [ubds_pkg::ClkW-1:0]       cfg_wdata,
  ubds_in_if.sink                         baud_in,
  ubds_out_if.source                      result_out
);

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_INT, S_FMUL, S_FRAC, S_AMULF, S_ACTF, S_RMUL,
    S_R1, S_R2, S_ACTR, S_TOL, S_EMUL, S_ECMP, S_NEXT, S_DIV, S_OUT
  } state_t;

  state_t                        state, ret;
  logic [ubds_pkg::ClkW-1:0]     clock_hz;
  logic [ubds_pkg::TolW-1:0]     tolerance_bp;
  logic [ubds_pkg::BaudW-1:0]    baud;
  logic [1:0]                    sel;
  logic [8:0]                    d1;
  logic [7:0]                    dint;
  logic [6:0]                    frac;
  logic                          fmode;
  logic [ubds_pkg::ClkW-1:0]     actual;
  logic [ubds_pkg::MulAW-1:0]    mul_a;
  logic [ubds_pkg::MulBW-1:0]    mul_b;
  logic [ubds_pkg::ProdW-1:0]    prod;
  logic [ubds_pkg::NumW-1:0]     num;
  logic [ubds_pkg::ClkW-1:0]     den;
  logic [ubds_pkg::ClkW-1:0]     rem;
  logic [ubds_pkg::CntW-1:0]     cnt;
  logic [ubds_pkg::ClkW-1:0]     clk_s;
  logic [ubds_pkg::ClkW-1:0]     denom;
  logic [ubds_pkg::ClkW:0]       rem_sh;
  logic [ubds_pkg::ClkW:0]       rem_sub;
  logic [ubds_pkg::ClkW:0]       diff;
  logic [ubds_pkg::ClkW-1:0]     mag;
  logic [8:0]                    r1;

  // Shared datapath pieces
  assign clk_s   = clock_hz >> {sel, 1'b0};
  assign denom   = {1'b0, baud, 3'b000};
  assign prod    = mul_a * mul_b;
  assign rem_sh  = {rem, num[ubds_pkg::NumW-1]};
  assign rem_sub = rem_sh - {1'b0, den};
  assign diff    = {1'b0, actual} - {5'd0, baud};
  assign mag     = diff[ubds_pkg::ClkW] ? ubds_pkg::ClkW'(-diff) : diff[ubds_pkg::ClkW-1:0];
  assign r1      = num[8:0] - 9'd1;

  assign baud_in.ready    = (state == S_IDLE);
  assign result_out.valid = (state == S_OUT);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz     <= ubds_pkg::ClockHzReset;
      tolerance_bp <= ubds_pkg::ToleranceReset;
    end else if (cfg_we) begin
      unique case (ubds_pkg::reg_index_t'(cfg_index))
        ubds_pkg::REG_CLOCK_HZ:  clock_hz     <= cfg_wdata;
        ubds_pkg::REG_TOLERANCE: tolerance_bp <= cfg_wdata[ubds_pkg::TolW-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and shared divider
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (baud_in.valid) begin
            baud <= baud_in.bit_rate;
            sel  <= 2'd0;
            result_out.status          <= ubds_pkg::STATUS_ERR;
            result_out.prescaler_sel   <= 2'd0;
            result_out.divisor_word    <= '0;
            result_out.fraction_enable <= 1'b0;
            state <= (baud_in.bit_rate == '0) ? S_OUT : S_START;
          end
        end
        S_START: begin
          num <= ubds_pkg::NumW'(clk_s);
          den <= denom;
          ret <= S_INT;
          cnt <= '0;
          rem <= '0;
          state <= S_DIV;
        end
        S_INT: begin
          // drop a zero or oversized integer divisor
          if (num == '0 || num > ubds_pkg::NumW'(256)) begin
            state <= S_NEXT;
          end else begin
            d1    <= num[8:0];
            dint  <= r1[7:0];
            mul_a <= ubds_pkg::MulAW'(num[8:0]);
            mul_b <= baud;
            state <= S_FMUL;
          end
        end
        S_FMUL: begin
          num <= ubds_pkg::NumW'({prod, 11'd0}) + ubds_pkg::NumW'(clk_s >> 1);
          den <= clk_s;
          ret <= S_FRAC;
          cnt <= '0;
          rem <= '0;
          state <= S_DIV;
        end
        S_FRAC: begin
          mul_a <= clk_s;
          if (num >= ubds_pkg::NumW'(128) && num <= ubds_pkg::NumW'(255)) begin
            frac  <= num[6:0];
            mul_b <= ubds_pkg::MulBW'(num[7:0]);
            state <= S_AMULF;
          end else begin
            mul_b <= ubds_pkg::RoundScale;
            state <= S_RMUL;
          end
        end
        S_AMULF: begin
          num   <= prod[ubds_pkg::NumW-1:0];
          den   <= ubds_pkg::ClkW'({d1, 11'd0});
          fmode <= 1'b1;
          ret   <= S_ACTF;
          cnt   <= '0;
          rem   <= '0;
          state <= S_DIV;
        end
        S_ACTF: begin
          actual <= num[ubds_pkg::ClkW-1:0];
          state  <= S_TOL;
        end
        S_RMUL: begin
          num <= prod[ubds_pkg::NumW-1:0];
          den <= denom;
          ret <= S_R1;
          cnt <= '0;
          rem <= '0;
          state <= S_DIV;
        end
        S_R1: begin
          num <= num + ubds_pkg::NumW'(5);
          den <= ubds_pkg::ClkW'(ubds_pkg::RoundScale);
          ret <= S_R2;
          cnt <= '0;
          rem <= '0;
          state <= S_DIV;
        end
        S_R2: begin
          if (num == '0 || num > ubds_pkg::NumW'(256)) begin
            state <= S_NEXT;
          end else begin
            dint  <= r1[7:0];
            frac  <= '0;
            fmode <= 1'b0;
            num   <= ubds_pkg::NumW'(clk_s);
            den   <= ubds_pkg::ClkW'({num[8:0], 3'b000});
            ret   <= S_ACTR;
            cnt   <= '0;
            rem   <= '0;
            state <= S_DIV;
          end
        end
        S_ACTR: begin
          actual <= num[ubds_pkg::ClkW-1:0];
          state  <= S_TOL;
        end
        S_TOL: begin
          mul_a <= mag;
          mul_b <= ubds_pkg::BpScale;
          state <= S_EMUL;
        end
        S_EMUL: begin
          num <= prod[ubds_pkg::NumW-1:0];
          den <= ubds_pkg::ClkW'(baud);
          ret <= S_ECMP;
          cnt <= '0;
          rem <= '0;
          state <= S_DIV;
        end
        S_ECMP: begin
          // error magnitude truncates toward zero, same as the signed quotient
          if (num <= ubds_pkg::NumW'(tolerance_bp)) begin
            result_out.status          <= ubds_pkg::STATUS_OK;
            result_out.prescaler_sel   <= sel;
            result_out.divisor_word    <= {dint, 1'b0, frac};
            result_out.fraction_enable <= fmode;
            state <= S_OUT;
          end else begin
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (sel == 2'd3) begin
            state <= S_OUT;
          end else begin
            sel   <= sel + 2'd1;
            state <= S_START;
          end
        end
        S_DIV: begin
          // one restoring step per cycle, quotient shifts into num
          if (!rem_sub[ubds_pkg::ClkW]) begin
            rem <= rem_sub[ubds_pkg::ClkW-1:0];
            num <= {num[ubds_pkg::NumW-2:0], 1'b1};
          end else begin
            rem <= rem_sh[ubds_pkg::ClkW-1:0];
            num <= {num[ubds_pkg::NumW-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == ubds_pkg::CntW'(ubds_pkg::NumW - 1)) state <= ret;
        end
        S_OUT: begin
          if (result_out.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* verif/ubds_checker.sv */
`timescale 1ns / 1ps
// Checker for the UART baud divisor search core: predicts each result word.
// Depends on ubds_pkg, ubds_in_if and ubds_out_if; watches both channels.
module ubds_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [ubds_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [ubds_pkg::ClkW-1:0]    cfg_wdata,
  ubds_in_if                           baud_in,
  ubds_out_if                          result_out,
  output int                           fail_count,
  output int                           pending_count,
  output int                           found_count,
  output int                           frac_count,
  output int                           err_count
);

  typedef struct packed {
    logic                       status;
    logic [1:0]                 sel;
    logic [ubds_pkg::WordW-1:0] word;
    logic                       frac_en;
  } baud_setting_t;

  logic [ubds_pkg::ClkW-1:0] clock_hz_q;
  logic [ubds_pkg::TolW-1:0] tol_bp_q;
  baud_setting_t             setting_q[$];

  // Rate error check; the difference is signed
  function automatic bit rate_ok(longint actual, longint baud, longint tol);
    longint diff;
    longint err;
    diff = actual - baud;
    err  = (diff * 10000) / baud;
    return !(err > tol || err < -tol);
  endfunction

  function automatic baud_setting_t search_divisor(logic [ubds_pkg::BaudW-1:0] rate);
    baud_setting_t r;
    longint baud;
    longint pclk;
    longint denom;
    longint dint;
    longint fraw;
    longint divr;
    longint actual;
    r = '{status: ubds_pkg::STATUS_ERR, sel: 2'd0, word: '0, frac_en: 1'b0};
    baud = longint'(rate);
    if (baud == 0) return r;
    for (int s = 0; s < 4; s++) begin
      pclk  = longint'(clock_hz_q) >> (2 * s);
      denom = 8 * baud;
      dint  = pclk / denom;
      if (dint == 0) continue;
      dint = dint - 1;
      if (dint > 255) continue;
      fraw = (2048 * (dint + 1) * baud + pclk / 2) / pclk;
      if (fraw >= 128 && fraw <= 255) begin
        actual = (pclk * fraw) / (2048 * (dint + 1));
        if (!rate_ok(actual, baud, longint'(tol_bp_q))) continue;
        r = '{status: ubds_pkg::STATUS_OK, sel: s[1:0],
              word: {dint[7:0], 1'b0, 7'(fraw - 128)}, frac_en: 1'b1};
        return r;
      end else begin
        divr = ((pclk * 10) / denom + 5) / 10;
        if (divr == 0) continue;
        divr = divr - 1;
        if (divr > 255) continue;
        actual = pclk / (8 * (divr + 1));
        if (!rate_ok(actual, baud, longint'(tol_bp_q))) continue;
        r = '{status: ubds_pkg::STATUS_OK, sel: s[1:0], word: {divr[7:0], 8'h00},
              frac_en: 1'b0};
        return r;
      end
    end
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  assign pending_count = setting_q.size();

  always_ff @(posedge clk) begin
    baud_setting_t e;
    if (rst) begin
      clock_hz_q <= ubds_pkg::ClockHzReset;
      tol_bp_q   <= ubds_pkg::ToleranceReset;
      setting_q.delete();
      fail_count  = 0;
      found_count <= 0;
      frac_count  <= 0;
      err_count   <= 0;
    end else begin
      // Hold register copies in step with the block
      if (cfg_we) begin
        if (cfg_index == ubds_pkg::REG_CLOCK_HZ) clock_hz_q <= cfg_wdata;
        else tol_bp_q <= cfg_wdata[ubds_pkg::TolW-1:0];
      end
      // Predict on each accepted word
      if (baud_in.valid && baud_in.ready) setting_q.push_back(search_divisor(baud_in.bit_rate));
      // Compare each delivered word with the oldest expectation
      if (result_out.valid && result_out.ready) begin
        if (setting_q.size() == 0) begin
          report("unexpected word", 32'd0, 32'd0);
        end else begin
          e = setting_q.pop_front();
          if (result_out.status !== e.status)
            report("status", 32'(result_out.status), 32'(e.status));
          if (result_out.prescaler_sel !== e.sel)
            report("prescaler_sel", 32'(result_out.prescaler_sel), 32'(e.sel));
          if (result_out.divisor_word !== e.word)
            report("divisor_word", 32'(result_out.divisor_word), 32'(e.word));
          if (result_out.fraction_enable !== e.frac_en)
            report("fraction_enable", 32'(result_out.fraction_enable), 32'(e.frac_en));
          if (e.status == ubds_pkg::STATUS_OK) found_count <= found_count + 1;
          else err_count <= err_count + 1;
          if (e.frac_en) frac_count <= frac_count + 1;
        end
      end
    end
  end
endmodule

/* verif/tb_uart_baud_divisor_search_core.sv */
`timescale 1ns / 1ps
// Testbench top for the UART baud divisor search core.
// Depends on ubds_pkg, the channel interfaces and ubds_checker.
module tb_uart_baud_divisor_search_core;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_we = 1'b0;
  logic [ubds_pkg::CfgIdxW-1:0] cfg_index = ubds_pkg::REG_CLOCK_HZ;
  logic [ubds_pkg::ClkW-1:0]    cfg_wdata = '0;
  int                 fail_count, pending_count, found_count, frac_count, err_count;
  int                 sent_count;
  bit                 no_idle;
  bit                 hold_off;

  ubds_in_if  baud_in();
  ubds_out_if result_out();

  uart_baud_divisor_search_core i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .baud_in(baud_in), .result_out(result_out)
  );

  ubds_checker i_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .baud_in(baud_in), .result_out(result_out),
    .fail_count(fail_count), .pending_count(pending_count),
    .found_count(found_count), .frac_count(frac_count), .err_count(err_count)
  );

  always #5 clk = ~clk;

  // Drop ready at random, or for a long hold-off
  always @(posedge clk) begin
    if (rst || hold_off) result_out.ready <= 1'b0;
    else result_out.ready <= no_idle || ($urandom_range(99) >= 18);
  end

  task automatic write_reg(ubds_pkg::reg_index_t idx, logic [ubds_pkg::ClkW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Offer one word; hold it until accepted, idle at random after
  task automatic send_rate(logic [ubds_pkg::BaudW-1:0] rate);
    baud_in.valid    <= 1'b1;
    baud_in.bit_rate <= rate;
    do @(posedge clk); while (!baud_in.ready);
    sent_count++;
    if (!no_idle && $urandom_range(99) < 18) begin
      baud_in.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain();
    @(posedge clk);
    baud_in.valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Mostly common rates near real settings, the rest random rates
  function automatic logic [ubds_pkg::BaudW-1:0] pick_rate();
    int unsigned common[8] = '{300, 1200, 9600, 19200, 57600, 115200, 460800, 1000000};
    case ($urandom_range(9))
      0:       return ubds_pkg::BaudW'($urandom());
      1:       return ubds_pkg::BaudW'($urandom_range(1, 300));
      2, 3:    return ubds_pkg::BaudW'($urandom_range(1, 2000000));
      default: return ubds_pkg::BaudW'(common[$urandom_range(7)] + $urandom_range(0, 64) - 32);
    endcase
  endfunction

  initial begin
    logic [ubds_pkg::ClkW-1:0] clocks[6] = '{ubds_pkg::ClockHzReset, 28'd1, 28'd200000000,
                                             28'd48000000, 28'd1843200, 28'd16000000};
    logic [ubds_pkg::TolW-1:0] tols[6]   = '{ubds_pkg::ToleranceReset, 14'd0, 14'd10000,
                                             14'd16383, 14'd100, 14'd500};
    baud_in.valid    = 1'b0;
    baud_in.bit_rate = '0;
    no_idle  = 1'b0;
    hold_off = 1'b0;
    sent_count = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: zero rate, rate field extremes and 9600 at reset and other settings
    foreach (clocks[i]) begin
      if (i != 0) begin
        write_reg(ubds_pkg::REG_CLOCK_HZ, clocks[i]);
        write_reg(ubds_pkg::REG_TOLERANCE, ubds_pkg::ClkW'(tols[i]));
      end
      send_rate('0);
      send_rate(24'hFFFFFF);
      send_rate(24'd1);
      send_rate(24'd9600);
      drain();
    end

    // Long stretch with no idling, then a receiver hold-off
    no_idle = 1'b1;
    for (int n = 0; n < 60; n++) send_rate(pick_rate());
    no_idle = 1'b0;
    fork
      begin
        hold_off = 1'b1;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int n = 0; n < 8; n++) send_rate(pick_rate());
    join
    drain();

    // Random phases over random and extreme settings
    for (int ph = 0; ph < 20; ph++) begin
      write_reg(ubds_pkg::REG_CLOCK_HZ, (ph % 4 == 0) ? clocks[ph % 6] :
                ubds_pkg::ClkW'($urandom_range(1, 200000000)));
      write_reg(ubds_pkg::REG_TOLERANCE, (ph % 3 == 0) ? ubds_pkg::ClkW'(tols[ph % 6]) :
                ubds_pkg::ClkW'($urandom_range(0, 16383)));
      for (int n = 0; n < 48; n++) send_rate(pick_rate());
      drain();
    end

    $display("covered %0d rates: %0d settings found (%0d fractional), %0d errors",
             sent_count, found_count, frac_count, err_count);
    if (fail_count == 0) $display("uart_baud_divisor_search_core regression: pass");
    else $display("uart_baud_divisor_search_core regression: fail");
    $finish;
  end

  initial begin
    #100ms;
    $display("uart_baud_divisor_search_core regression: fail");
    $finish;
  end
endmodule
